/* rtl/qrv_pkg.sv */
// Shared types and constants for the quaternion vector rotation block.
`default_nettype none
package qrv_pkg;

	localparam int FRAC_BITS = 14;
	localparam int VEC_WIDTH = 16;
	localparam int REG_WIDTH = 16;
	localparam int OUT_WIDTH = 16;

	localparam logic signed [REG_WIDTH-1:0] QX_RESET = 16'sd0;
	localparam logic signed [REG_WIDTH-1:0] QY_RESET = 16'sd0;
	localparam logic signed [REG_WIDTH-1:0] QZ_RESET = 16'sd0;
	localparam logic signed [REG_WIDTH-1:0] QW_RESET = 16'sd16384;

	typedef enum logic [1:0] {
		REG_QX = 2'd0,
		REG_QY = 2'd1,
		REG_QZ = 2'd2,
		REG_QW = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [VEC_WIDTH-1:0] vec_x;
		logic signed [VEC_WIDTH-1:0] vec_y;
		logic signed [VEC_WIDTH-1:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] out_x;
		logic signed [OUT_WIDTH-1:0] out_y;
		logic signed [OUT_WIDTH-1:0] out_z;
		logic                        zero_length;
	} res_t;

endpackage
`default_nettype wire

/* rtl/qrv_norm.sv */
// Pipelined normalization of a vector to unit length with exact rounding.
`default_nettype none
module qrv_norm #(
	parameter int FRAC_BITS = qrv_pkg::FRAC_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      valid,
	input  wire qrv_pkg::vec_t             vec,
	output logic                           n_valid,
	output logic                           n_zero,
	output logic signed [FRAC_BITS+1:0]    nx,
	output logic signed [FRAC_BITS+1:0]    ny,
	output logic signed [FRAC_BITS+1:0]    nz
);
	localparam int VW  = qrv_pkg::VEC_WIDTH;
	localparam int MW  = 2 * VW;
	localparam int MSW = MW + 1;
	localparam int QW  = MSW + FRAC_BITS + 3;
	localparam int PW  = MSW + 2 * FRAC_BITS + 6;
	localparam int NU  = FRAC_BITS + 1;
	localparam int NW  = FRAC_BITS + 2;
	localparam int NS  = FRAC_BITS + 1;

	logic [VW-1:0]        a [3];
	logic [MW-1:0]        a2 [3];
	logic signed [VW-1:0] v [3];

	logic                 valid_s1;
	logic                 zero_s1;
	logic [2:0]           neg_s1;
	logic [MW-1:0]        a2_s1 [3];

	logic [MW-1:0]        msum;

	// Search pipeline: index 0 is the entry, index j+1 follows search step j.
	logic                  srch_valid_s [0:NS];
	logic                  srch_zero_s  [0:NS];
	logic [2:0]            srch_neg_s   [0:NS];
	logic signed [MSW-1:0] srch_m_s     [0:NS];
	logic signed [PW-1:0]  srch_r2_s    [0:NS][3];
	logic signed [PW-1:0]  srch_p_s     [0:NS][3];
	logic signed [QW-1:0]  srch_q_s     [0:NS][3];
	logic [NU-1:0]         srch_n_s     [0:NS][3];

	assign v[0] = vec.vec_x;
	assign v[1] = vec.vec_y;
	assign v[2] = vec.vec_z;

	always_comb begin
		logic signed [VW:0] wide;
		logic signed [VW:0] negw;
		for (int l = 0; l < 3; l++) begin
			wide  = {v[l][VW-1], v[l]};
			negw  = -wide;
			a[l]  = v[l][VW-1] ? negw[VW-1:0] : wide[VW-1:0];
			a2[l] = MW'(a[l]) * MW'(a[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (vec.vec_x == '0) && (vec.vec_y == '0) && (vec.vec_z == '0);
			neg_s1  <= {v[2][VW-1], v[1][VW-1], v[0][VW-1]};
			for (int l = 0; l < 3; l++) begin
				a2_s1[l] <= a2[l];
			end
		end
	end

	assign msum = a2_s1[0] + a2_s1[1] + a2_s1[2];

	// The squared magnitude is at most three times the largest square, so it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_valid_s[0] <= 1'b0;
		end else if (en) begin
			srch_valid_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srch_zero_s[0] <= zero_s1;
			srch_neg_s[0]  <= neg_s1;
			srch_m_s[0]    <= $signed({1'b0, msum});
			for (int l = 0; l < 3; l++) begin
				srch_r2_s[0][l] <= $signed(PW'(a2_s1[l])) <<< (2 * FRAC_BITS + 2);
				srch_p_s[0][l]  <= PW'($signed({1'b0, msum}));
				srch_q_s[0][l]  <= -QW'($signed({1'b0, msum}));
				srch_n_s[0][l]  <= '0;
			end
		end
	end

	// Each step tries one bit of n, keeping (2n-1)^2*m and (2n-1)*m by shifts and adds.
	for (genvar j = 0; j < NS; j++) begin : g_step
		localparam int K = FRAC_BITS - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				srch_valid_s[j+1] <= 1'b0;
			end else if (en) begin
				srch_valid_s[j+1] <= srch_valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				srch_zero_s[j+1] <= srch_zero_s[j];
				srch_neg_s[j+1]  <= srch_neg_s[j];
				srch_m_s[j+1]    <= srch_m_s[j];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic signed [PW-1:0] cand;
			logic                 take;

			assign cand = srch_p_s[j][l]
				+ (PW'(srch_q_s[j][l]) <<< (K + 2))
				+ (PW'(srch_m_s[j]) <<< (2 * K + 2));
			assign take = (cand <= srch_r2_s[j][l]);

			always_ff @(posedge clk) begin
				if (en) begin
					srch_r2_s[j+1][l] <= srch_r2_s[j][l];
					srch_p_s[j+1][l]  <= take ? cand : srch_p_s[j][l];
					srch_q_s[j+1][l]  <= take
						? srch_q_s[j][l] + (QW'(srch_m_s[j]) <<< (K + 1))
						: srch_q_s[j][l];
					srch_n_s[j+1][l]  <= take
						? (srch_n_s[j][l] | (NU'(1) << K))
						: srch_n_s[j][l];
				end
			end
		end
	end

	assign n_valid = srch_valid_s[NS];
	assign n_zero  = srch_zero_s[NS];

	always_comb begin
		logic signed [NW-1:0] mag [3];
		for (int l = 0; l < 3; l++) begin
			mag[l] = $signed({1'b0, srch_n_s[NS][l]});
		end
		nx = srch_neg_s[NS][0] ? -mag[0] : mag[0];
		ny = srch_neg_s[NS][1] ? -mag[1] : mag[1];
		nz = srch_neg_s[NS][2] ? -mag[2] : mag[2];
	end

endmodule
`default_nettype wire

/* rtl/quaternion_rotate_vector.sv */
// Throughput: one vector per cycle; every stage advances whenever the output register is
// empty or its result is being taken, so the search for the unit vector, one bit per stage,
// and the multiply and sum stages of both Hamilton products all run fully pipelined.
// Reset clears all valid bits and loads the identity rotation into the quaternion registers.
`default_nettype none
module quaternion_rotate_vector #(
	parameter int FRAC_BITS = qrv_pkg::FRAC_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          vec_valid,
	output logic                               vec_stall,
	input  wire qrv_pkg::vec_t                 vec,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output qrv_pkg::res_t                      res,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire qrv_pkg::cfg_idx_t             cfg_index,
	input  wire logic [qrv_pkg::REG_WIDTH-1:0] cfg_data
);
	localparam int QW  = qrv_pkg::REG_WIDTH;
	localparam int NW  = FRAC_BITS + 2;
	localparam int P1W = NW + QW;
	localparam int S1W = P1W + 2;
	localparam int RW  = S1W - FRAC_BITS;
	localparam int P2W = RW + QW;
	localparam int S2W = P2W + 2;
	localparam int OW  = S2W - FRAC_BITS;
	localparam int OUW = qrv_pkg::OUT_WIDTH;
	localparam logic signed [OW-1:0] OMAX = OW'((2 ** (OUW - 1)) - 1);
	localparam logic signed [OW-1:0] OMIN = -OW'(2 ** (OUW - 1));

	logic en;

	logic signed [QW-1:0] qx_q, qy_q, qz_q, qw_q;

	logic                 n_valid, n_zero;
	logic signed [NW-1:0] nx, ny, nz;

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  zero_s1, zero_s2, zero_s3;
	logic signed [P1W-1:0] p1_s1 [12];
	logic signed [RW-1:0]  rx_s2, ry_s2, rz_s2, rw_s2;
	logic signed [P2W-1:0] p2_s3 [12];

	logic signed [RW-1:0]  rx, ry, rz, rw;
	logic signed [OW-1:0]  ox, oy, oz;

	assign en        = !res_valid || !res_stall;
	assign vec_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= qrv_pkg::QX_RESET;
			qy_q <= qrv_pkg::QY_RESET;
			qz_q <= qrv_pkg::QZ_RESET;
			qw_q <= qrv_pkg::QW_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				qrv_pkg::REG_QX: begin
					qx_q <= $signed(cfg_data);
				end
				qrv_pkg::REG_QY: begin
					qy_q <= $signed(cfg_data);
				end
				qrv_pkg::REG_QZ: begin
					qz_q <= $signed(cfg_data);
				end
				qrv_pkg::REG_QW: begin
					qw_q <= $signed(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	qrv_norm #(
		.FRAC_BITS(FRAC_BITS)
	) u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (vec_valid),
		.vec     (vec),
		.n_valid (n_valid),
		.n_zero  (n_zero),
		.nx      (nx),
		.ny      (ny),
		.nz      (nz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= n_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			res_valid <= valid_s3;
		end
	end

	// First product (n, 0) * conj(q): the twelve partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1   <= n_zero;
			p1_s1[0]  <= P1W'(nx) * P1W'(qw_q);
			p1_s1[1]  <= P1W'(ny) * P1W'(qz_q);
			p1_s1[2]  <= P1W'(nz) * P1W'(qy_q);
			p1_s1[3]  <= P1W'(ny) * P1W'(qw_q);
			p1_s1[4]  <= P1W'(nz) * P1W'(qx_q);
			p1_s1[5]  <= P1W'(nx) * P1W'(qz_q);
			p1_s1[6]  <= P1W'(nz) * P1W'(qw_q);
			p1_s1[7]  <= P1W'(nx) * P1W'(qy_q);
			p1_s1[8]  <= P1W'(ny) * P1W'(qx_q);
			p1_s1[9]  <= P1W'(nx) * P1W'(qx_q);
			p1_s1[10] <= P1W'(ny) * P1W'(qy_q);
			p1_s1[11] <= P1W'(nz) * P1W'(qz_q);
		end
	end

	// Sums are rounded half up by adding half an LSB and shifting arithmetically.
	always_comb begin
		logic signed [S1W-1:0] half;
		logic signed [S1W-1:0] sx, sy, sz, sw;
		half = S1W'(1) <<< (FRAC_BITS - 1);
		sx = S1W'(p1_s1[0]) - S1W'(p1_s1[1]) + S1W'(p1_s1[2]) + half;
		sy = S1W'(p1_s1[3]) - S1W'(p1_s1[4]) + S1W'(p1_s1[5]) + half;
		sz = S1W'(p1_s1[6]) - S1W'(p1_s1[7]) + S1W'(p1_s1[8]) + half;
		sw = S1W'(p1_s1[9]) + S1W'(p1_s1[10]) + S1W'(p1_s1[11]) + half;
		rx = RW'(sx >>> FRAC_BITS);
		ry = RW'(sy >>> FRAC_BITS);
		rz = RW'(sz >>> FRAC_BITS);
		rw = RW'(sw >>> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			rx_s2   <= rx;
			ry_s2   <= ry;
			rz_s2   <= rz;
			rw_s2   <= rw;
		end
	end

	// Second product q * r, vector part only.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3   <= zero_s2;
			p2_s3[0]  <= P2W'(qw_q) * P2W'(rx_s2);
			p2_s3[1]  <= P2W'(qx_q) * P2W'(rw_s2);
			p2_s3[2]  <= P2W'(qy_q) * P2W'(rz_s2);
			p2_s3[3]  <= P2W'(qz_q) * P2W'(ry_s2);
			p2_s3[4]  <= P2W'(qw_q) * P2W'(ry_s2);
			p2_s3[5]  <= P2W'(qy_q) * P2W'(rw_s2);
			p2_s3[6]  <= P2W'(qz_q) * P2W'(rx_s2);
			p2_s3[7]  <= P2W'(qx_q) * P2W'(rz_s2);
			p2_s3[8]  <= P2W'(qw_q) * P2W'(rz_s2);
			p2_s3[9]  <= P2W'(qz_q) * P2W'(rw_s2);
			p2_s3[10] <= P2W'(qx_q) * P2W'(ry_s2);
			p2_s3[11] <= P2W'(qy_q) * P2W'(rx_s2);
		end
	end

	always_comb begin
		logic signed [S2W-1:0] half;
		logic signed [S2W-1:0] sx, sy, sz;
		half = S2W'(1) <<< (FRAC_BITS - 1);
		sx = S2W'(p2_s3[0]) + S2W'(p2_s3[1]) + S2W'(p2_s3[2]) - S2W'(p2_s3[3]) + half;
		sy = S2W'(p2_s3[4]) + S2W'(p2_s3[5]) + S2W'(p2_s3[6]) - S2W'(p2_s3[7]) + half;
		sz = S2W'(p2_s3[8]) + S2W'(p2_s3[9]) + S2W'(p2_s3[10]) - S2W'(p2_s3[11]) + half;
		ox = OW'(sx >>> FRAC_BITS);
		oy = OW'(sy >>> FRAC_BITS);
		oz = OW'(sz >>> FRAC_BITS);
	end

	function automatic logic signed [OUW-1:0] sat(input logic signed [OW-1:0] val);
		logic signed [OW-1:0] lim;
		lim = (val > OMAX) ? OMAX : ((val < OMIN) ? OMIN : val);
		return lim[OUW-1:0];
	endfunction

	// A zero vector leaves the search meaningless, so its outputs are forced to zero.
	always_ff @(posedge clk) begin
		if (en) begin
			res.zero_length <= zero_s3;
			res.out_x       <= zero_s3 ? '0 : sat(ox);
			res.out_y       <= zero_s3 ? '0 : sat(oy);
			res.out_z       <= zero_s3 ? '0 : sat(oz);
		end
	end

endmodule
`default_nettype wire

/* bench/quaternion_rotate_vector_tb.sv */
// Testbench for quaternion_rotate_vector: random and directed vectors checked against a predictor.
`timescale 1ns / 1ps
module quaternion_rotate_vector_tb;

	localparam int F = qrv_pkg::FRAC_BITS;
	localparam int LATENCY = F + 7;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vec_valid = 1'b0;
	logic vec_stall;
	qrv_pkg::vec_t vec = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	qrv_pkg::res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	qrv_pkg::cfg_idx_t cfg_index = qrv_pkg::REG_QX;
	logic [qrv_pkg::REG_WIDTH-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int take_idle_pct = 0;
	int mismatches = 0;
	longint cycles = 0;
	logic signed [qrv_pkg::REG_WIDTH-1:0] rot_q [4];
	qrv_pkg::res_t rotated_queue [$];

	quaternion_rotate_vector uut (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The largest n with (2n-1)^2 * mag2 <= (2 * a * 2^F)^2, found by binary search.
	function automatic longint unit_part(longint v, longint mag2);
		longint a, lo, hi, mid;
		logic [127:0] lhs, rhs, t, r;
		a = (v < 0) ? -v : v;
		lo = 0;
		hi = longint'(1) << F;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			t = 128'(2 * mid - 1);
			r = 128'(a) << (F + 1);
			lhs = t * t * 128'(mag2);
			rhs = r * r;
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return (v < 0) ? -lo : lo;
	endfunction

	function automatic longint round_q(longint s);
		return (s + (longint'(1) << (F - 1))) >>> F;
	endfunction

	function automatic logic signed [qrv_pkg::OUT_WIDTH-1:0] clamp16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic qrv_pkg::res_t rotate_vec(qrv_pkg::vec_t v);
		qrv_pkg::res_t o;
		longint vx, vy, vz, qx, qy, qz, qw, mag2, nx, ny, nz, rx, ry, rz, rw;
		vx = v.vec_x; vy = v.vec_y; vz = v.vec_z;
		qx = rot_q[qrv_pkg::REG_QX]; qy = rot_q[qrv_pkg::REG_QY];
		qz = rot_q[qrv_pkg::REG_QZ]; qw = rot_q[qrv_pkg::REG_QW];
		o = '0;
		if (vx == 0 && vy == 0 && vz == 0) begin
			o.zero_length = 1'b1;
			return o;
		end
		mag2 = vx * vx + vy * vy + vz * vz;
		nx = unit_part(vx, mag2);
		ny = unit_part(vy, mag2);
		nz = unit_part(vz, mag2);
		rx = round_q(nx * qw - ny * qz + nz * qy);
		ry = round_q(ny * qw - nz * qx + nx * qz);
		rz = round_q(nz * qw - nx * qy + ny * qx);
		rw = round_q(nx * qx + ny * qy + nz * qz);
		o.out_x = clamp16(round_q(qw * rx + qx * rw + qy * rz - qz * ry));
		o.out_y = clamp16(round_q(qw * ry + qy * rw + qz * rx - qx * rz));
		o.out_z = clamp16(round_q(qw * rz + qz * rw + qx * ry - qy * rx));
		return o;
	endfunction

	// Valid stays high after the transaction so that a following one can go back to back.
	task automatic send_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		qrv_pkg::vec_t v;
		v.vec_x = x; v.vec_y = y; v.vec_z = z;
		while ($urandom_range(99) < send_idle_pct) begin
			vec_valid <= 1'b0;
			@(posedge clk);
		end
		vec_valid <= 1'b1;
		vec <= v;
		@(posedge clk);
		while (vec_stall) @(posedge clk);
		rotated_queue.push_back(rotate_vec(v));
	endtask

	task automatic drain();
		vec_valid <= 1'b0;
		while (rotated_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(qrv_pkg::cfg_idx_t idx, logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		rot_q[idx] = d;
	endtask

	task automatic set_rotation(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
		drain();
		write_reg(qrv_pkg::REG_QX, x);
		write_reg(qrv_pkg::REG_QY, y);
		write_reg(qrv_pkg::REG_QZ, z);
		write_reg(qrv_pkg::REG_QW, w);
		cfg_valid <= 1'b0;
	endtask

	// Field extremes, axis vectors and the zero vector, under the identity rotation and several others.
	task automatic test_directed();
		send_vec(0, 0, 0);
		send_vec(16'h7fff, 0, 0);
		send_vec(0, 16'h8000, 0);
		send_vec(0, 0, 1);
		send_vec(16'h8000, 16'h8000, 16'h8000);
		send_vec(16'h7fff, 16'h7fff, 16'h7fff);
		send_vec(16'hffff, 1, 16'hffff);
		send_vec(3, 4, 0);
		send_vec(16'h7fff, 16'h8000, 1);
		send_vec(0, 0, 0);
		set_rotation(16'h2d41, 0, 0, 16'h2d41);
		send_vec(1, 0, 0);
		send_vec(0, 1, 0);
		send_vec(0, 0, 16'h8000);
		set_rotation(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_vec(16'h7fff, 1, 16'h8000);
		send_vec(5, 16'hfff0, 100);
		set_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_vec(16'h1234, 16'h8000, 16'h7fff);
		send_vec(0, 0, 0);
		set_rotation(0, 16'h8000, 0, 0);
		send_vec(1, 2, 3);
		set_rotation(0, 0, 0, 16'h4000);
	endtask

	task automatic random_vectors(int n);
		logic [15:0] x, y, z;
		for (int i = 0; i < n; i++) begin
			x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
			case ($urandom_range(9))
				0: begin
					x = 16'($urandom_range(3)); y = 16'($urandom_range(3)); z = 0;
				end
				1: begin y = 0; z = 0; end
				2: begin x = 16'($urandom_range(7) - 4); end
				3: begin x = 0; y = 0; z = 0; end
				default: ;
			endcase
			send_vec(x, y, z);
		end
	endtask

	// Each block of random vectors runs under a fresh rotation, unit-ish or not.
	task automatic test_random(int blocks, int per_block);
		for (int b = 0; b < blocks; b++) begin
			if ($urandom_range(1))
				set_rotation(16'($urandom_range(32767) - 16384),
					16'($urandom_range(32767) - 16384),
					16'($urandom_range(32767) - 16384),
					16'($urandom_range(32767) - 16384));
			else
				set_rotation(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			random_vectors(per_block);
		end
	endtask

	task automatic test_pause();
		random_vectors(20);
		vec_valid <= 1'b0;
		while (rotated_queue.size() != 0) @(posedge clk);
		random_vectors(20);
	endtask

	always @(posedge clk) begin
		if (arst_n)
			res_stall <= ($urandom_range(99) < take_idle_pct);
	end

	always @(posedge clk) begin
		qrv_pkg::res_t want;
		cycles++;
		if (arst_n && res_valid && !res_stall) begin
			if (rotated_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", res);
			end else begin
				want = rotated_queue.pop_front();
				if (res.out_x !== want.out_x || res.out_y !== want.out_y ||
					res.out_z !== want.out_z || res.zero_length !== want.zero_length) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d z%0b, got %0d %0d %0d z%0b",
							want.out_x, want.out_y, want.out_z, want.zero_length,
							res.out_x, res.out_y, res.out_z, res.zero_length);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL quaternion_rotate_vector");
			$finish;
		end
	end

	initial begin
		rot_q[qrv_pkg::REG_QX] = qrv_pkg::QX_RESET;
		rot_q[qrv_pkg::REG_QY] = qrv_pkg::QY_RESET;
		rot_q[qrv_pkg::REG_QZ] = qrv_pkg::QZ_RESET;
		rot_q[qrv_pkg::REG_QW] = qrv_pkg::QW_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 18;
		take_idle_pct = 60;
		test_random(6, 90);
		test_pause();
		send_idle_pct = 60;
		take_idle_pct = 18;
		test_random(6, 90);
		send_idle_pct = 0;
		take_idle_pct = 0;
		test_random(6, 90);
		set_rotation(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		random_vectors(60);
		drain();
		if (mismatches == 0 && rotated_queue.size() == 0)
			$display("PASS quaternion_rotate_vector");
		else
			$display("FAIL quaternion_rotate_vector");
		$finish;
	end

endmodule
